// ===== rtl/core/sfr_pkg.sv =====
// types and constants shared by the frame receiver modules
// no dependencies
`default_nettype none

package sfr_pkg;

    localparam int MODE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 4;
    localparam int LEN_OUT_W = 5;
    localparam int PHASE_W   = 3;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h55;

    typedef enum logic [MODE_W-1:0] {
        MODE_BYTE = 2'd0,
        MODE_POLL = 2'd1,
        MODE_READ = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_SYNC1  = 3'd1,
        PH_LENGTH = 3'd2,
        PH_DATA   = 3'd3,
        PH_READY  = 3'd4
    } phase_t;

    // result fields that come from the parser for one transaction
    typedef struct packed {
        logic                 frame_ready;
        logic                 length_error;
        logic [LEN_OUT_W-1:0] frame_length;
        phase_t               phase;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfr_parser.sv =====
// frame parser: sync register, phase, length and write position state
// depends on sfr_pkg
`default_nettype none

module sfr_parser #(
    parameter int BUFFER_DEPTH = 16,
    localparam int POS_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [sfr_pkg::BYTE_W-1:0] cfg_wr_data,
    input  wire logic                       take,
    input  wire sfr_pkg::mode_t             mode,
    input  wire logic [sfr_pkg::BYTE_W-1:0] byte_value,
    output logic                            wr_en,
    output logic      [POS_W-1:0]           wr_addr,
    output logic      [sfr_pkg::BYTE_W-1:0] wr_data,
    output sfr_pkg::status_t                status
);

    localparam int LEN_W = $clog2(BUFFER_DEPTH + 1);
    localparam int LEN_X = (LEN_W > sfr_pkg::LEN_OUT_W) ? LEN_W : sfr_pkg::LEN_OUT_W;

    logic [sfr_pkg::BYTE_W-1:0] sync_reg;
    sfr_pkg::phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]           length_reg, length_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [LEN_W-1:0]           pos_inc;
    logic                       is_sync;
    logic                       len_err;
    logic [LEN_X-1:0]           length_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= sfr_pkg::SYNC_RESET;
        end
        else if (cfg_wr_en)
        begin
            sync_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= sfr_pkg::PH_IDLE;
            length_reg <= '0;
            pos_reg    <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
        end
    end

    assign is_sync = (byte_value == sync_reg);
    assign pos_inc = LEN_W'(pos_reg) + LEN_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        len_err     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = byte_value;
        case (mode)
            sfr_pkg::MODE_BYTE:
            begin
                case (phase_reg)
                    sfr_pkg::PH_SYNC1:
                    begin
                        phase_next = is_sync ? sfr_pkg::PH_LENGTH : sfr_pkg::PH_IDLE;
                    end
                    sfr_pkg::PH_LENGTH:
                    begin
                        if (byte_value == '0)
                        begin
                            // empty frame completes at once
                            length_next = '0;
                            pos_next    = '0;
                            phase_next  = sfr_pkg::PH_READY;
                        end
                        else if (byte_value > sfr_pkg::BYTE_W'(BUFFER_DEPTH))
                        begin
                            len_err    = 1'b1;
                            phase_next = sfr_pkg::PH_IDLE;
                        end
                        else
                        begin
                            length_next = LEN_W'(byte_value);
                            pos_next    = '0;
                            phase_next  = sfr_pkg::PH_DATA;
                        end
                    end
                    sfr_pkg::PH_DATA:
                    begin
                        if ((LEN_W'(pos_reg) < length_reg) &&
                            ((LEN_W + 1)'(pos_reg) < (LEN_W + 1)'(BUFFER_DEPTH)))
                        begin
                            wr_en = take;
                            if (pos_inc == length_reg)
                            begin
                                pos_next   = '0;
                                phase_next = sfr_pkg::PH_READY;
                            end
                            else
                            begin
                                pos_next = pos_inc[POS_W-1:0];
                            end
                        end
                        else
                        begin
                            pos_next   = '0;
                            phase_next = sfr_pkg::PH_IDLE;
                        end
                    end
                    sfr_pkg::PH_READY:
                    begin
                        // bytes are dropped until the frame is polled
                    end
                    default:
                    begin
                        // idle, and unreachable codes behave as idle
                        phase_next = is_sync ? sfr_pkg::PH_SYNC1 : sfr_pkg::PH_IDLE;
                    end
                endcase
            end
            sfr_pkg::MODE_POLL:
            begin
                if (phase_reg == sfr_pkg::PH_READY)
                begin
                    phase_next = sfr_pkg::PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign length_ext = LEN_X'(length_next);

    assign status.frame_ready  = (mode == sfr_pkg::MODE_POLL) &&
                                 (phase_reg == sfr_pkg::PH_READY);
    assign status.length_error = len_err;
    assign status.frame_length = length_ext[sfr_pkg::LEN_OUT_W-1:0];
    assign status.phase        = phase_next;

endmodule

`default_nettype wire

// ===== rtl/core/sync_length_frame_receiver.sv =====
// sync/length framed byte receiver: parses frames into a payload buffer
// result is registered in the cycle after its input; throughput: one transaction per cycle
// when not stalled, set by the parser update and the payload ram's registered read port
// a held result does not stop input as long as the downstream side takes it in the same cycle
// reset: asynchronous active low; parser idle, sync byte 0x55, payload buffer not cleared
// depends on sfr_pkg, sfr_parser, sfr_ram
`default_nettype none

module sync_length_frame_receiver #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [sfr_pkg::BYTE_W-1:0] cfg_wr_data,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [15:0]                s_tdata,  // byte_value[7:0], read_index[11:8]
    input  wire logic [sfr_pkg::MODE_W-1:0] s_tuser,  // mode[1:0]
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // frame_ready[0], read_data[8:1], frame_length[13:9], parser_phase[16:14],
    // length_error[17]
    output logic      [23:0]                m_tdata
);

    localparam int POS_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int IDX_X = (POS_W > sfr_pkg::INDEX_W) ? POS_W : sfr_pkg::INDEX_W;

    logic                          accept;
    sfr_pkg::mode_t                mode;
    logic [sfr_pkg::BYTE_W-1:0]    byte_value;
    logic [sfr_pkg::INDEX_W-1:0]   read_index;
    logic [IDX_X-1:0]              index_ext;
    logic                          in_range;
    logic                          rd_en;

    logic                          wr_en;
    logic [POS_W-1:0]              wr_addr;
    logic [sfr_pkg::BYTE_W-1:0]    wr_data;
    logic [sfr_pkg::BYTE_W-1:0]    ram_q;
    sfr_pkg::status_t              status;

    logic                          valid_reg;
    sfr_pkg::status_t              status_reg;
    logic                          rd_sel_reg;
    logic [sfr_pkg::BYTE_W-1:0]    read_data;

    assign mode       = sfr_pkg::mode_t'(s_tuser);
    assign byte_value = s_tdata[7:0];
    assign read_index = s_tdata[11:8];

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign index_ext = IDX_X'(read_index);
    assign in_range  = (9'(read_index) < 9'(BUFFER_DEPTH));
    assign rd_en     = accept && (mode == sfr_pkg::MODE_READ) && in_range;

    sfr_parser #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .take        (accept),
        .mode        (mode),
        .byte_value  (byte_value),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .status      (status)
    );

    // read data register inside the ram doubles as part of the result register
    sfr_ram #(
        .WIDTH (sfr_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_payload (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (index_ext[POS_W-1:0]),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status;
            rd_sel_reg <= rd_en;
        end
    end

    assign read_data = rd_sel_reg ? ram_q : '0;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, status_reg.length_error, status_reg.phase,
                       status_reg.frame_length, read_data, status_reg.frame_ready};

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench for sync_length_frame_receiver: directed frames, random streams, a held output
// checked per transaction against a frame parser predictor; depends on sfr_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH         = 16;
    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic             frame_ready;
        logic [7:0]       read_data;
        logic [4:0]       frame_length;
        sfr_pkg::phase_t  phase;
        logic             length_error;
    } frame_status_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = sfr_pkg::SYNC_RESET;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = sfr_pkg::MODE_NOP;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;

    // parser copy kept by the bench
    logic [7:0]      sync_value  = sfr_pkg::SYNC_RESET;
    sfr_pkg::phase_t pr_phase    = sfr_pkg::PH_IDLE;
    logic [4:0]      pr_length   = '0;
    int unsigned     pr_wpos     = 0;
    logic [7:0]      pr_payload [DEPTH];
    bit              written    [DEPTH];

    frame_status_t status_q[$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_left      = 0;
    bit          hold_req       = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned ignored_sent   = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned frames_polled  = 0;
    int unsigned len_errors     = 0;

    sync_length_frame_receiver #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: run did not complete");
        $display("Mismatches found");
        $finish;
    end

    // advances the parser copy by one input transaction
    function automatic frame_status_t parse_step(sfr_pkg::mode_t m, logic [7:0] b,
                                                 logic [3:0] idx);
        frame_status_t r;
        r = '0;
        case (m)
            sfr_pkg::MODE_BYTE:
            begin
                case (pr_phase)
                    sfr_pkg::PH_SYNC1:
                        pr_phase = (b == sync_value) ? sfr_pkg::PH_LENGTH : sfr_pkg::PH_IDLE;
                    sfr_pkg::PH_LENGTH:
                    begin
                        if (b == 8'd0)
                        begin
                            pr_length = '0;
                            pr_wpos   = 0;
                            pr_phase  = sfr_pkg::PH_READY;
                        end
                        else if (b > DEPTH)
                        begin
                            r.length_error = 1'b1;
                            pr_phase       = sfr_pkg::PH_IDLE;
                        end
                        else
                        begin
                            pr_length = b[4:0];
                            pr_wpos   = 0;
                            pr_phase  = sfr_pkg::PH_DATA;
                        end
                    end
                    sfr_pkg::PH_DATA:
                    begin
                        if (pr_wpos < pr_length && pr_wpos < DEPTH)
                        begin
                            pr_payload[pr_wpos] = b;
                            written[pr_wpos]    = 1'b1;
                            pr_wpos++;
                            if (pr_wpos == pr_length)
                            begin
                                pr_wpos  = 0;
                                pr_phase = sfr_pkg::PH_READY;
                            end
                        end
                        else
                        begin
                            pr_wpos  = 0;
                            pr_phase = sfr_pkg::PH_IDLE;
                        end
                    end
                    sfr_pkg::PH_READY: ;
                    default:
                        pr_phase = (b == sync_value) ? sfr_pkg::PH_SYNC1 : sfr_pkg::PH_IDLE;
                endcase
            end
            sfr_pkg::MODE_POLL:
            begin
                if (pr_phase == sfr_pkg::PH_READY)
                begin
                    r.frame_ready = 1'b1;
                    pr_phase      = sfr_pkg::PH_IDLE;
                end
            end
            sfr_pkg::MODE_READ: r.read_data = pr_payload[idx];
            default: ;
        endcase
        r.frame_length = pr_length;
        r.phase        = pr_phase;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // input side predicts, output side compares with the oldest expectation
    always @(posedge clk)
    begin
        frame_status_t want;
        frame_status_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                status_q.push_back(parse_step(sfr_pkg::mode_t'(s_tuser), s_tdata[7:0],
                                              s_tdata[11:8]));
                items_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                got.frame_ready  = m_tdata[0];
                got.read_data    = m_tdata[8:1];
                got.frame_length = m_tdata[13:9];
                got.phase        = sfr_pkg::phase_t'(m_tdata[16:14]);
                got.length_error = m_tdata[17];
                results_seen++;
                if (got.frame_ready)
                    frames_polled++;
                if (got.length_error)
                    len_errors++;
                if (status_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("frame_ready", want.frame_ready, got.frame_ready);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("frame_length", want.frame_length, got.frame_length);
                    check_field("parser_phase", want.phase, got.phase);
                    check_field("length_error", want.length_error, got.length_error);
                end
            end
        end
    end

    // output ready: random stalls, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_item(sfr_pkg::mode_t m, logic [7:0] b, logic [3:0] idx);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {4'h0, idx, b};
        items_sent++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(sfr_pkg::MODE_BYTE, b, 4'($urandom_range(15)));
    endtask

    task automatic send_poll();
        send_item(sfr_pkg::MODE_POLL, 8'($urandom_range(255)), 4'($urandom_range(15)));
    endtask

    // reads only entries that some frame has already filled
    task automatic send_read();
        int unsigned idx;
        bit          any;
        any = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            any |= written[i];
        if (!any)
            send_item(sfr_pkg::MODE_NOP, 8'($urandom_range(255)), 4'($urandom_range(15)));
        else
        begin
            idx = $urandom_range(DEPTH - 1);
            while (!written[idx])
                idx = (idx + 1) % DEPTH;
            send_item(sfr_pkg::MODE_READ, 8'($urandom_range(255)), 4'(idx));
        end
    endtask

    task automatic send_frame(int unsigned len, int unsigned cut);
        send_byte(sync_value);
        send_byte(sync_value);
        send_byte(8'(len));
        if (len >= 1 && len <= DEPTH)
            repeat (cut) send_byte(8'($urandom_range(255)));
    endtask

    function automatic int unsigned pick_length();
        case ($urandom_range(9))
            0:       return 0;
            1:       return DEPTH;
            2:       return $urandom_range(255, DEPTH + 1);
            3:       return 1;
            default: return $urandom_range(8, 2);
        endcase
    endfunction

    task automatic wait_idle();
        int unsigned n;
        n = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (status_q.size() > 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sync(logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sync_value   = v;
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_poll();                                 // poll with no frame waiting
        send_item(sfr_pkg::MODE_NOP, 8'hFF, 4'hF);
        send_byte(8'h55);
        send_byte(8'h00);                            // second header byte wrong
        send_byte(8'hAA);                            // first header byte wrong
        send_frame(DEPTH + 1, 0);                    // just over the buffer depth
        send_frame(255, 0);
        send_frame(0, 0);                            // zero length completes at once
        send_byte(8'h55);                            // ignored while ready
        send_poll();
        send_byte(8'h55);
        send_byte(8'h55);
        send_byte(8'd2);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_poll();
        send_item(sfr_pkg::MODE_READ, 8'h00, 4'd0);
        send_item(sfr_pkg::MODE_READ, 8'hFF, 4'd1);
        wait_idle();
    endtask

    task automatic run_random(int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        stop_at = items_sent - ignored_sent + n;
        while (items_sent - ignored_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                len = pick_length();
                // an occasional frame is cut short
                cut = ($urandom_range(9) == 0 && len <= DEPTH) ? $urandom_range(len) : len;
                send_poll();
                send_frame(len, cut);
                if (cut == len && len <= DEPTH)
                begin
                    repeat ($urandom_range(2))
                    begin
                        send_byte(8'($urandom_range(255)));
                        ignored_sent++;
                    end
                end
                send_poll();
                repeat ($urandom_range(3)) send_read();
            end
            else if (pick < 80)
            begin
                case ($urandom_range(2))
                    0:       send_poll();
                    1:       send_read();
                    default: send_item(sfr_pkg::MODE_NOP, 8'($urandom_range(255)),
                                       4'($urandom_range(15)));
                endcase
            end
            else
                send_byte(($urandom_range(3) == 0) ? sync_value : 8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_phase(int unsigned src_pct, int unsigned sink_pct,
                                     logic [7:0] sync, int unsigned n);
        write_sync(sync);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        run_random(n);
        wait_idle();
    endtask

    // output held off while input keeps coming, so the block must stall its input
    task automatic test_backpressure();
        write_sync(sfr_pkg::SYNC_RESET);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b1;
        repeat (3)
        begin
            send_poll();
            send_frame(8, 8);
            send_poll();
            repeat (4) send_read();
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 8'h00, 250);
        test_random_phase(49, 0, 8'hFF, 250);
        test_random_phase(0, 49, 8'($urandom_range(255)), 250);
        test_random_phase(11, 11, sfr_pkg::SYNC_RESET, 250);
        test_backpressure();

        if (status_q.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d results expected, actual 0 arrived", $time, status_q.size());
        end

        $display("%0d transactions in, %0d results out, %0d frames polled, %0d length errors",
                 items_accepted, results_seen, frames_polled, len_errors);
        $display("sync bytes 0x55, 0x00, 0xFF and a random one; four idle mixes, one long hold");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
